// ===== rtl/plfs_pkg.sv =====
// Package: shared constants and word layouts for the PWM LED fade sequencer.
`timescale 1ns / 1ps

package plfs_pkg;

  // Default sizing
  localparam int LED_COUNT_DEF = 8;
  localparam int PWM_CYCLE_DEF = 25;

  // Fade step register
  localparam int       STEP_W        = 7;
  localparam logic [6:0] FADE_STEP_RST = 7'd5;

  // Level in percent
  localparam int         LEVEL_W    = 7;
  localparam logic [6:0] LEVEL_FULL = 7'd100;
  localparam logic [6:0] LEVEL_ZERO = 7'd0;

  // Duty / counter widths
  localparam int DUTY_W = 8;
  localparam int PINS_W = 8;
  localparam int ACT_W  = 3;

  // Input word: bit positions from the lowest bit up
  localparam int IN_START  = 0;
  localparam int IN_STOP   = 1;
  localparam int IN_RESET  = 2;
  localparam int IN_STEP   = 3;
  localparam int IN_PWM    = 4;
  localparam int IN_FLD_W  = 5;
  localparam int IN_TDATA_W = 8;

  // Output word: bit positions from the lowest bit up
  localparam int OUT_PINS_LO = 0;
  localparam int OUT_ACT_LO  = 8;
  localparam int OUT_LVL_LO  = 11;
  localparam int OUT_DOWN    = 18;
  localparam int OUT_RUN     = 19;
  localparam int OUT_FLD_W   = 20;
  localparam int OUT_TDATA_W = 24;

  // Input flags of one word
  typedef struct packed {
    logic pwm_tick;
    logic step_tick;
    logic reset_button;
    logic stop_button;
    logic start_button;
  } in_flags_t;

  // Result fields of one word
  typedef struct packed {
    logic              is_running;
    logic              fading_down;
    logic [LEVEL_W-1:0] brightness;
    logic [ACT_W-1:0]  active_led;
    logic [PINS_W-1:0] led_pins;
  } out_fields_t;

endpackage

// ===== rtl/pwm_led_fade_sequencer.sv =====
// Top level: chaser fade sequencer driving a shared-counter software PWM.
// Path: an accepted word waits in the input register and is processed into the
//   result register once that is free or draining; out_tvalid then offers it.
// Throughput: one input word per cycle while out_tready drains the results;
//   all work sits between the input register and the result register.
// Reset (rst_n low, synchronous): pipeline empty, all duties, PWM counter,
//   pins, index, level, direction and running cleared, fade_step = 5.
`timescale 1ns / 1ps

module pwm_led_fade_sequencer #(
  parameter int LED_COUNT = plfs_pkg::LED_COUNT_DEF,
  parameter int PWM_CYCLE = plfs_pkg::PWM_CYCLE_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // config: fade_step[6:0]
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [plfs_pkg::STEP_W-1:0]      cfg_data,
  // in_tdata: start_button, stop_button, reset_button, step_tick, pwm_tick,
  //   zero pad [7:5]
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [plfs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: led_pins[7:0], active_led[10:8], brightness[17:11],
  //   fading_down[18], is_running[19], zero pad [23:20]
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [plfs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import plfs_pkg::*;

  localparam int IDX_W = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int NPINS = (LED_COUNT < PINS_W) ? LED_COUNT : PINS_W;
  localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(LED_COUNT - 1);
  localparam logic [DUTY_W-1:0] CNT_LAST = DUTY_W'(PWM_CYCLE - 1);

  // Duty lookup: PWM_CYCLE*min(pct,100)/100, worked out at elaboration
  logic [DUTY_W-1:0] duty_tab [0:127];
  for (genvar g = 0; g < 128; g++) begin : g_duty
    localparam int Pct  = (g > 100) ? 100 : g;
    localparam int Duty = (PWM_CYCLE * Pct) / 100;
    assign duty_tab[g] = DUTY_W'(Duty);
  end

  // Registers
  logic [STEP_W-1:0]  fade_step_r;
  logic               in_vld_r;
  in_flags_t          in_flags_r;
  logic               out_vld_r;
  out_fields_t        out_fields_r;
  logic [DUTY_W-1:0]  duty_r [LED_COUNT];
  logic [DUTY_W-1:0]  cnt_r;
  logic [PINS_W-1:0]  pins_r;
  logic [IDX_W-1:0]   idx_r;
  logic [LEVEL_W-1:0] lvl_r;
  logic               down_r;
  logic               run_r;

  // Next values
  logic [DUTY_W-1:0]  duty_nxt [LED_COUNT];
  logic [DUTY_W-1:0]  cnt_nxt;
  logic [PINS_W-1:0]  pins_nxt;
  logic [IDX_W-1:0]   idx_nxt;
  logic [LEVEL_W-1:0] lvl_nxt;
  logic               down_nxt;
  logic               run_nxt;
  out_fields_t        out_fields_nxt;

  logic               proc_fire;
  logic [LEVEL_W:0]   up_sum;
  logic [31:0]        idx_ext;

  // Handshake
  assign proc_fire  = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !in_vld_r || proc_fire;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {(OUT_TDATA_W - OUT_FLD_W)'(0), out_fields_r};

  // Fade step register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fade_step_r <= FADE_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      fade_step_r <= cfg_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_flags_r <= in_flags_t'(in_tdata[IN_FLD_W-1:0]);
    end
  end

  // One word of work: buttons, fade step, PWM sample
  always_comb begin
    run_nxt  = run_r;
    idx_nxt  = idx_r;
    lvl_nxt  = lvl_r;
    down_nxt = down_r;
    cnt_nxt  = cnt_r;
    pins_nxt = pins_r;
    up_sum   = {1'b0, lvl_r} + {1'b0, fade_step_r};
    for (int i = 0; i < LED_COUNT; i++) begin
      duty_nxt[i] = duty_r[i];
    end

    // buttons: start, then stop, then reset
    if (in_flags_r.start_button) begin
      run_nxt = 1'b1;
    end
    if (in_flags_r.stop_button) begin
      run_nxt = 1'b0;
    end
    if (in_flags_r.reset_button) begin
      run_nxt  = 1'b1;
      idx_nxt  = '0;
      lvl_nxt  = LEVEL_ZERO;
      down_nxt = 1'b0;
      up_sum   = {1'b0, fade_step_r};
      for (int i = 0; i < LED_COUNT; i++) begin
        duty_nxt[i] = '0;
      end
    end

    // fade step on the LED now active
    if (in_flags_r.step_tick && run_nxt) begin
      if (!down_nxt) begin
        if (up_sum >= {1'b0, LEVEL_FULL}) begin
          duty_nxt[idx_nxt] = duty_tab[LEVEL_FULL];
          if (idx_nxt == IDX_LAST) begin
            idx_nxt  = '0;
            lvl_nxt  = LEVEL_FULL;
            down_nxt = 1'b1;
          end else begin
            idx_nxt = idx_nxt + 1'b1;
            lvl_nxt = LEVEL_ZERO;
          end
        end else begin
          lvl_nxt           = up_sum[LEVEL_W-1:0];
          duty_nxt[idx_nxt] = duty_tab[up_sum[LEVEL_W-1:0]];
        end
      end else begin
        if (lvl_nxt <= fade_step_r) begin
          duty_nxt[idx_nxt] = '0;
          if (idx_nxt == IDX_LAST) begin
            idx_nxt  = '0;
            lvl_nxt  = LEVEL_ZERO;
            down_nxt = 1'b0;
          end else begin
            idx_nxt = idx_nxt + 1'b1;
            lvl_nxt = LEVEL_FULL;
          end
        end else begin
          lvl_nxt           = lvl_nxt - fade_step_r;
          duty_nxt[idx_nxt] = duty_tab[lvl_nxt];
        end
      end
    end

    // PWM sample against the updated duties, then advance the counter
    if (in_flags_r.pwm_tick) begin
      pins_nxt = '0;
      for (int i = 0; i < NPINS; i++) begin
        pins_nxt[i] = (duty_nxt[i] != '0) && (duty_nxt[i] >= cnt_r);
      end
      cnt_nxt = (cnt_r == CNT_LAST) ? '0 : cnt_r + 1'b1;
    end
  end

  // Result word fields
  assign idx_ext = 32'(idx_nxt);
  always_comb begin
    out_fields_nxt.led_pins    = pins_nxt;
    out_fields_nxt.active_led  = idx_ext[ACT_W-1:0];
    out_fields_nxt.brightness  = lvl_nxt;
    out_fields_nxt.fading_down = down_nxt;
    out_fields_nxt.is_running  = run_nxt;
  end

  // Sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      pins_r <= '0;
      idx_r  <= '0;
      lvl_r  <= LEVEL_ZERO;
      down_r <= 1'b0;
      run_r  <= 1'b0;
      for (int i = 0; i < LED_COUNT; i++) begin
        duty_r[i] <= '0;
      end
    end else if (proc_fire) begin
      cnt_r  <= cnt_nxt;
      pins_r <= pins_nxt;
      idx_r  <= idx_nxt;
      lvl_r  <= lvl_nxt;
      down_r <= down_nxt;
      run_r  <= run_nxt;
      for (int i = 0; i < LED_COUNT; i++) begin
        duty_r[i] <= duty_nxt[i];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (proc_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_fields_r <= out_fields_nxt;
    end
  end

endmodule

// ===== rtl/plfs_checker.sv =====
// Checker: port-level properties of the fade sequencer, bound to the top level.
`timescale 1ns / 1ps

module plfs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [plfs_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import plfs_pkg::*;

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  // Reset empties the result stage
  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // Brightness never exceeds full scale
  a_lvl_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_LVL_LO +: LEVEL_W] <= LEVEL_FULL)
    else $error("brightness above 100");

  // A new result word comes from an accepted input word
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(in_tvalid && in_tready, 2))
    else $error("result word without an accepted input word");

endmodule

bind pwm_led_fade_sequencer plfs_checker u_plfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
